// ----- rtl/tmpe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmpe_pkg
// Shared widths, codes and control bundles of the trial-move energy block.
// ----------------------------------------------------------------------------
package tmpe_pkg;

  // Position memory size and the widths that follow from it.
  localparam int MAX_SPHERES = 1024;
  localparam int IDX_W       = $clog2(MAX_SPHERES);
  localparam int EFF_W       = IDX_W + 1;

  // Field widths.
  localparam int IDX_IN_W   = 10;
  localparam int CNT_W      = 11;
  localparam int POS_W      = 24;
  localparam int VAL_W      = 25;
  localparam int E_W        = 48;
  localparam int MEM_W      = 3 * POS_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Pair unit arithmetic widths.
  localparam int SQ_W       = 2 * POS_W;
  localparam int R2_W       = SQ_W + 2;
  localparam int DIV_W      = 33;
  localparam int Q_W        = 29;
  localparam int DIV_STAGES = Q_W;
  localparam int PE_W       = 37;
  localparam int ACC_W      = 50;

  // WCA cutoff at r2 = 2^(1/3) and the close-contact limit of 1/16, both Q.32.
  localparam logic [R2_W-1:0]  WCA_CUT_R2 = R2_W'(64'd5411319704);
  localparam logic [R2_W-1:0]  CLOSE_R2   = R2_W'(64'd268435456);
  localparam logic [DIV_W-1:0] REM_INIT   = DIV_W'(64'd134217728);
  localparam logic [PE_W-1:0]  PAIR_E_MAX = {PE_W{1'b1}};

  // Register reset values.
  localparam logic [POS_W-1:0] BOX_RESET   = POS_W'(655360);
  localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(2);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WALLS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 3'd4;

  // Command codes.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TRIAL = 1'b1;

  // Controller to datapath commands.
  typedef struct packed {
    logic ld_in;
    logic mem_wr;
    logic rd_old;
    logic ld_old;
    logic acc_clr;
    logic cnt_clr;
    logic issue;
    logic ld_out;
  } tmpe_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic bad_idx;
    logic is_trial;
    logic cnt_last;
    logic pipe_busy;
  } tmpe_sts_t;

endpackage

// ----- rtl/tmpe_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmpe_in_if
// Command channel: write a sphere position or evaluate a trial move.
// ----------------------------------------------------------------------------
interface tmpe_in_if;
  import tmpe_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    command;
  logic [IDX_IN_W-1:0]     sphere_index;
  logic signed [VAL_W-1:0] value_x;
  logic signed [VAL_W-1:0] value_y;
  logic signed [VAL_W-1:0] value_z;

  modport source (output valid, command, sphere_index, value_x, value_y, value_z,
                  input ready);
  modport sink (input valid, command, sphere_index, value_x, value_y, value_z,
                output ready);
endinterface

// ----- rtl/tmpe_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmpe_out_if
// Result channel: energy change, corrected position and index error flag.
// ----------------------------------------------------------------------------
interface tmpe_out_if;
  import tmpe_pkg::*;

  logic                  valid;
  logic                  ready;
  logic signed [E_W-1:0] energy_change;
  logic [POS_W-1:0]      moved_x;
  logic [POS_W-1:0]      moved_y;
  logic [POS_W-1:0]      moved_z;
  logic                  bad_index;

  modport source (output valid, energy_change, moved_x, moved_y, moved_z, bad_index,
                  input ready);
  modport sink (input valid, energy_change, moved_x, moved_y, moved_z, bad_index,
                output ready);
endinterface

// ----- rtl/tmpe_cfg_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmpe_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface tmpe_cfg_if;
  import tmpe_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/tmpe_pair_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmpe_pair_unit
// Pipelined WCA pair energy: nearest-image distance, r2, a radix-2 pipelined
// reciprocal, s6 and the clamped energy. Accepts one pair every cycle.
// ----------------------------------------------------------------------------
module tmpe_pair_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_v,
  input  logic                                 in_neg,
  input  logic [2:0][tmpe_pkg::POS_W-1:0]      pos_j,
  input  logic [2:0][tmpe_pkg::POS_W-1:0]      ref_p,
  input  logic [2:0][tmpe_pkg::POS_W-1:0]      box_len,
  input  logic [2:0]                           walls,
  output logic                                 out_v,
  output logic                                 out_neg,
  output logic [tmpe_pkg::PE_W-1:0]            out_e,
  output logic                                 busy
);
  import tmpe_pkg::*;

  localparam int DW = POS_W + 2;

  // Stage A1: per-axis distance, after nearest image on axes without walls.
  logic                  a1_v_r, a1_neg_r;
  logic [2:0][POS_W-1:0] a1_ad_r;
  logic [2:0][POS_W-1:0] ad_c;

  always_comb begin
    logic signed [DW-1:0] d;
    logic signed [DW-1:0] ad;
    logic signed [DW-1:0] lq;
    for (int a = 0; a < 3; a++) begin
      lq = $signed({2'b00, box_len[a]});
      d  = $signed({2'b00, pos_j[a]}) - $signed({2'b00, ref_p[a]});
      ad = (d < 0) ? -d : d;
      if (!walls[a] && ((ad <<< 1) > lq)) begin
        d = (d < 0) ? d + lq : d - lq;
      end
      ad = (d < 0) ? -d : d;
      ad_c[a] = ad[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a1_v_r <= 1'b0;
    end else begin
      a1_v_r <= in_v;
    end
    a1_neg_r <= in_neg;
    a1_ad_r  <= ad_c;
  end

  // Stage A2: squares, one multiplier per axis.
  logic                 a2_v_r, a2_neg_r;
  logic [2:0][SQ_W-1:0] a2_sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a2_v_r <= 1'b0;
    end else begin
      a2_v_r <= a1_v_r;
    end
    a2_neg_r <= a1_neg_r;
    for (int a = 0; a < 3; a++) begin
      a2_sq_r[a] <= a1_ad_r[a] * a1_ad_r[a];
    end
  end

  // Stage D0: r2 and its range class, seeding the divider.
  logic [R2_W-1:0] r2_c;
  assign r2_c = R2_W'(a2_sq_r[0]) + R2_W'(a2_sq_r[1]) + R2_W'(a2_sq_r[2]);

  logic [DIV_STAGES:0] dv_v_r;
  logic                dv_neg_r  [DIV_STAGES+1];
  logic                dv_far_r  [DIV_STAGES+1];
  logic                dv_near_r [DIV_STAGES+1];
  logic [DIV_W-1:0]    dv_d_r    [DIV_STAGES+1];
  logic [DIV_W-1:0]    dv_rem_r  [DIV_STAGES+1];
  logic [Q_W-1:0]      dv_q_r    [DIV_STAGES+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else begin
      dv_v_r[0] <= a2_v_r;
    end
    dv_neg_r[0]  <= a2_neg_r;
    dv_far_r[0]  <= (r2_c > WCA_CUT_R2);
    dv_near_r[0] <= (r2_c < CLOSE_R2);
    dv_d_r[0]    <= r2_c[DIV_W-1:0];
    dv_rem_r[0]  <= REM_INIT;
    dv_q_r[0]    <= '0;
  end

  // Divider stages: one quotient bit of 2^56 / r2 per stage.
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    logic [DIV_W:0] trial;
    logic           ge;
    assign trial = {dv_rem_r[k], 1'b0};
    assign ge    = (trial >= {1'b0, dv_d_r[k]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k+1] <= 1'b0;
      end else begin
        dv_v_r[k+1] <= dv_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      dv_neg_r[k+1]  <= dv_neg_r[k];
      dv_far_r[k+1]  <= dv_far_r[k];
      dv_near_r[k+1] <= dv_near_r[k];
      dv_d_r[k+1]    <= dv_d_r[k];
      dv_rem_r[k+1]  <= ge ? DIV_W'(trial - {1'b0, dv_d_r[k]}) : trial[DIV_W-1:0];
      dv_q_r[k+1]    <= {dv_q_r[k][Q_W-2:0], ge};
    end
  end

  // Stage M1: s2 squared.
  logic                 m1_v_r, m1_neg_r, m1_far_r, m1_near_r;
  logic [Q_W-1:0]       m1_s2_r;
  logic [2*Q_W-1:0]     m1_p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
    end else begin
      m1_v_r <= dv_v_r[DIV_STAGES];
    end
    m1_neg_r  <= dv_neg_r[DIV_STAGES];
    m1_far_r  <= dv_far_r[DIV_STAGES];
    m1_near_r <= dv_near_r[DIV_STAGES];
    m1_s2_r   <= dv_q_r[DIV_STAGES];
    m1_p_r    <= dv_q_r[DIV_STAGES] * dv_q_r[DIV_STAGES];
  end

  // Stage M2: s4 times s2.
  localparam int S4_W = 2 * Q_W - 24;
  localparam int P2_W = S4_W + Q_W;

  logic             m2_v_r, m2_neg_r, m2_far_r, m2_near_r;
  logic [P2_W-1:0]  m2_p_r;
  logic [S4_W-1:0]  s4_c;
  assign s4_c = m1_p_r[2*Q_W-1:24];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_v_r <= 1'b0;
    end else begin
      m2_v_r <= m1_v_r;
    end
    m2_neg_r  <= m1_neg_r;
    m2_far_r  <= m1_far_r;
    m2_near_r <= m1_near_r;
    m2_p_r    <= s4_c * m1_s2_r;
  end

  // Stage M3: s6 in Q.16 and the product s6 * (s6 - 1).
  logic                 m3_v_r, m3_neg_r, m3_far_r, m3_near_r;
  logic signed [63:0]   m3_prod_r;
  logic signed [31:0]   s6q_c;
  logic signed [31:0]   s6m_c;
  assign s6q_c = $signed(32'(m2_p_r[P2_W-1:32]));
  assign s6m_c = s6q_c - 32'sd65536;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m3_v_r <= 1'b0;
    end else begin
      m3_v_r <= m2_v_r;
    end
    m3_neg_r  <= m2_neg_r;
    m3_far_r  <= m2_far_r;
    m3_near_r <= m2_near_r;
    m3_prod_r <= s6q_c * s6m_c;
  end

  // Stage M4: energy 4*prod + 1, clamped and floored to Q.16.
  logic signed [63:0] e_full_c;
  logic [63:0]        e_sh_c;
  logic [PE_W-1:0]    e_c;
  logic               out_v_r, out_neg_r;
  logic [PE_W-1:0]    out_e_r;

  always_comb begin
    e_full_c = (m3_prod_r <<< 2) + 64'sd4294967296;
    e_sh_c   = 64'(e_full_c) >> 16;
    if (m3_far_r) begin
      e_c = '0;
    end else if (m3_near_r) begin
      e_c = PAIR_E_MAX;
    end else if (e_full_c < 0) begin
      e_c = '0;
    end else if (e_sh_c > 64'(PAIR_E_MAX)) begin
      e_c = PAIR_E_MAX;
    end else begin
      e_c = e_sh_c[PE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= m3_v_r;
    end
    out_neg_r <= m3_neg_r;
    out_e_r   <= e_c;
  end

  assign out_v   = out_v_r;
  assign out_neg = out_neg_r;
  assign out_e   = out_e_r;
  assign busy    = a1_v_r | a2_v_r | (|dv_v_r) | m1_v_r | m2_v_r | m3_v_r | out_v_r;

endmodule

// ----- rtl/tmpe_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmpe_datapath
// Configuration registers, position memory, boundary correction, sweep
// counter, pair unit, energy accumulator and result registers.
// ----------------------------------------------------------------------------
module tmpe_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [tmpe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tmpe_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_command,
  input  logic [tmpe_pkg::IDX_IN_W-1:0]       in_sphere_index,
  input  logic signed [tmpe_pkg::VAL_W-1:0]   in_value_x,
  input  logic signed [tmpe_pkg::VAL_W-1:0]   in_value_y,
  input  logic signed [tmpe_pkg::VAL_W-1:0]   in_value_z,
  input  tmpe_pkg::tmpe_cmd_t                 cmd,
  output tmpe_pkg::tmpe_sts_t                 sts,
  output logic signed [tmpe_pkg::E_W-1:0]     energy_change,
  output logic [tmpe_pkg::POS_W-1:0]          moved_x,
  output logic [tmpe_pkg::POS_W-1:0]          moved_y,
  output logic [tmpe_pkg::POS_W-1:0]          moved_z,
  output logic                                bad_index
);
  import tmpe_pkg::*;

  localparam logic signed [ACC_W-1:0] ACC_HI =
    $signed({{(ACC_W-E_W+1){1'b0}}, {(E_W-1){1'b1}}});
  localparam logic signed [ACC_W-1:0] ACC_LO =
    $signed({{(ACC_W-E_W+1){1'b1}}, {(E_W-1){1'b0}}});
  localparam int NW = POS_W + 4;

  // Configuration registers.
  logic [2:0][POS_W-1:0] box_r;
  logic [2:0]            walls_r;
  logic [CNT_W-1:0]      count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r   <= {BOX_RESET, BOX_RESET, BOX_RESET};
      walls_r <= '0;
      count_r <= COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BOX_X: box_r[0] <= cfg_data[POS_W-1:0];
        CFG_BOX_Y: box_r[1] <= cfg_data[POS_W-1:0];
        CFG_BOX_Z: box_r[2] <= cfg_data[POS_W-1:0];
        CFG_WALLS: walls_r  <= cfg_data[2:0];
        CFG_COUNT: count_r  <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sphere count in use, limited to the memory depth.
  logic [EFF_W-1:0] eff;
  assign eff = (32'(count_r) > MAX_SPHERES) ? EFF_W'(MAX_SPHERES) : EFF_W'(count_r);

  // Captured transaction.
  logic                         cmd_r;
  logic [IDX_IN_W-1:0]          idx_r;
  logic signed [2:0][VAL_W-1:0] val_r;

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      cmd_r    <= in_command;
      idx_r    <= in_sphere_index;
      val_r[0] <= in_value_x;
      val_r[1] <= in_value_y;
      val_r[2] <= in_value_z;
    end
  end

  // Written positions: negative values store zero.
  logic [2:0][POS_W-1:0] wpos;
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      wpos[a] = val_r[a][VAL_W-1] ? '0 : val_r[a][POS_W-1:0];
    end
  end

  // Sweep counter over the spheres in use.
  logic [EFF_W-1:0] cnt_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.issue) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // Position memory with a registered read port.
  logic [MEM_W-1:0] mem [MAX_SPHERES];
  logic [MEM_W-1:0] rdata_r;
  logic [IDX_W-1:0] rd_addr;
  logic             rd_en;
  assign rd_addr = cmd.rd_old ? IDX_W'(idx_r) : cnt_r[IDX_W-1:0];
  assign rd_en   = cmd.rd_old | cmd.issue;

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[IDX_W'(idx_r)] <= {wpos[2], wpos[1], wpos[0]};
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  logic [2:0][POS_W-1:0] rpos;
  assign rpos = rdata_r;

  // Trial position: one wrap or reflection per axis, then clamp to [0, L].
  logic [2:0][POS_W-1:0] np_c;
  always_comb begin
    logic signed [NW-1:0] n;
    logic signed [NW-1:0] lq;
    for (int a = 0; a < 3; a++) begin
      lq = $signed({4'b0000, box_r[a]});
      n  = $signed({4'b0000, rpos[a]}) + NW'($signed(val_r[a]));
      if (n > lq) begin
        n = walls_r[a] ? (lq <<< 1) - n : n - lq;
      end else if (n < 0) begin
        n = walls_r[a] ? -n : n + lq;
      end
      if (n < 0) begin
        n = '0;
      end
      if (n > lq) begin
        n = lq;
      end
      np_c[a] = n[POS_W-1:0];
    end
  end

  logic [2:0][POS_W-1:0] op_r;
  logic [2:0][POS_W-1:0] np_r;
  always_ff @(posedge clk) begin
    if (cmd.ld_old) begin
      op_r <= rpos;
      np_r <= np_c;
    end
  end

  // Each read sphere but the moved one feeds the pair unit twice: old reference, then new.
  logic rv1_r, rv2_r, skipa_r, skipb_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv1_r   <= 1'b0;
      rv2_r   <= 1'b0;
      skipa_r <= 1'b0;
      skipb_r <= 1'b0;
    end else begin
      rv1_r   <= cmd.issue;
      rv2_r   <= rv1_r;
      skipa_r <= (32'(cnt_r) == 32'(idx_r));
      skipb_r <= skipa_r;
    end
  end

  logic                  feed_v;
  logic [2:0][POS_W-1:0] ref_sel;
  logic                  pu_v, pu_neg, pu_busy;
  logic [PE_W-1:0]       pu_e;
  assign feed_v  = (rv1_r & ~skipa_r) | (rv2_r & ~skipb_r);
  assign ref_sel = rv2_r ? np_r : op_r;

  tmpe_pair_unit u_pair (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_v    (feed_v),
    .in_neg  (rv1_r),
    .pos_j   (rpos),
    .ref_p   (ref_sel),
    .box_len (box_r),
    .walls   (walls_r),
    .out_v   (pu_v),
    .out_neg (pu_neg),
    .out_e   (pu_e),
    .busy    (pu_busy)
  );

  // Energy accumulator: new energies add, old energies subtract.
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] e_ext;
  assign e_ext = $signed({{(ACC_W-PE_W){1'b0}}, pu_e});

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (pu_v) begin
      acc_r <= pu_neg ? acc_r - e_ext : acc_r + e_ext;
    end
  end

  logic signed [E_W-1:0] delta_c;
  always_comb begin
    if (acc_r > ACC_HI) begin
      delta_c = ACC_HI[E_W-1:0];
    end else if (acc_r < ACC_LO) begin
      delta_c = ACC_LO[E_W-1:0];
    end else begin
      delta_c = acc_r[E_W-1:0];
    end
  end

  // Status to the controller.
  logic bad_c;
  assign bad_c = (32'(idx_r) >= 32'(eff));
  assign sts.bad_idx   = bad_c;
  assign sts.is_trial  = (cmd_r == CMD_TRIAL);
  assign sts.cnt_last  = (cnt_r == eff - 1'b1);
  assign sts.pipe_busy = rv1_r | rv2_r | pu_busy;

  // Result registers.
  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      if (bad_c) begin
        energy_change <= '0;
        moved_x       <= '0;
        moved_y       <= '0;
        moved_z       <= '0;
        bad_index     <= 1'b1;
      end else if (cmd_r == CMD_WRITE) begin
        energy_change <= '0;
        moved_x       <= wpos[0];
        moved_y       <= wpos[1];
        moved_z       <= wpos[2];
        bad_index     <= 1'b0;
      end else begin
        energy_change <= delta_c;
        moved_x       <= np_r[0];
        moved_y       <= np_r[1];
        moved_z       <= np_r[2];
        bad_index     <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/tmpe_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmpe_ctrl
// Sequencer: decode, old position read, sweep over the stored spheres,
// pipeline drain and result hand-off with a one-entry output register.
// ----------------------------------------------------------------------------
module tmpe_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tmpe_pkg::tmpe_cmd_t  cmd,
  input  tmpe_pkg::tmpe_sts_t  sts
);
  import tmpe_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_LDOLD  = 3'd2;
  localparam logic [2:0] S_SWEEP  = 3'd3;
  localparam logic [2:0] S_DRAIN  = 3'd4;
  localparam logic [2:0] S_RESULT = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       phase_r, phase_nxt;
  logic       out_valid_r;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_in = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.bad_idx) begin
          state_nxt = S_RESULT;
        end else if (!sts.is_trial) begin
          cmd.mem_wr = 1'b1;
          state_nxt  = S_RESULT;
        end else begin
          cmd.rd_old  = 1'b1;
          cmd.acc_clr = 1'b1;
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_LDOLD;
        end
      end
      S_LDOLD: begin
        cmd.ld_old = 1'b1;
        phase_nxt  = 1'b0;
        state_nxt  = S_SWEEP;
      end
      S_SWEEP: begin
        phase_nxt = ~phase_r;
        if (!phase_r) begin
          cmd.issue = 1'b1;
          if (sts.cnt_last) begin
            state_nxt = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!out_valid_r || out_ready) begin
          cmd.ld_out = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      if (cmd.ld_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- rtl/trial_move_pair_energy_delta.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trial_move_pair_energy_delta
// WCA trial-move energy change over a stored sphere set.
//
//   channel  direction  contents
//   in_if    sink       command, sphere_index, value_x/y/z
//   out_if   source     energy_change, moved_x/y/z, bad_index
//   cfg_if   sink       index, data (box lengths, wall flags, sphere count)
//
// A write or a bad index goes straight to the result. A trial reads the
// stored spheres in turn through the one read port of the position memory;
// each one other than the moved sphere is paired twice (old and new position)
// in one pipelined pair unit that resolves one quotient bit per divider stage.
// Reset is synchronous, active low; the memory is not cleared.
// A new transaction is taken while the previous result waits in the output
// register; configuration writes are taken in every cycle.
// ----------------------------------------------------------------------------
module trial_move_pair_energy_delta (
  input  logic        clk,
  input  logic        rst_n,
  tmpe_in_if.sink     in_if,
  tmpe_out_if.source  out_if,
  tmpe_cfg_if.sink    cfg_if
);
  import tmpe_pkg::*;

  tmpe_cmd_t cmd;
  tmpe_sts_t sts;

  assign cfg_if.ready = 1'b1;

  // Sequencer.
  tmpe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Datapath.
  tmpe_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_if.valid),
    .cfg_index       (cfg_if.index),
    .cfg_data        (cfg_if.data),
    .in_command      (in_if.command),
    .in_sphere_index (in_if.sphere_index),
    .in_value_x      (in_if.value_x),
    .in_value_y      (in_if.value_y),
    .in_value_z      (in_if.value_z),
    .cmd             (cmd),
    .sts             (sts),
    .energy_change   (out_if.energy_change),
    .moved_x         (out_if.moved_x),
    .moved_y         (out_if.moved_y),
    .moved_z         (out_if.moved_z),
    .bad_index       (out_if.bad_index)
  );

endmodule

// ----- rtl/tmpe_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmpe_checker
// Port-level checks of the trial-move energy block, bound to the top level.
// ----------------------------------------------------------------------------
module tmpe_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [tmpe_pkg::E_W-1:0]   energy_change,
  input logic [tmpe_pkg::POS_W-1:0]        moved_x,
  input logic [tmpe_pkg::POS_W-1:0]        moved_y,
  input logic [tmpe_pkg::POS_W-1:0]        moved_z,
  input logic                              bad_index
);
  import tmpe_pkg::*;

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(energy_change) &&
      $stable(moved_x) && $stable(moved_y) && $stable(moved_z) && $stable(bad_index))
    else $error("result changed while stalled");

  // An index error carries an all-zero payload.
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && bad_index |-> energy_change == 0 && moved_x == 0 &&
      moved_y == 0 && moved_z == 0)
    else $error("index error with nonzero payload");

  // One transaction at a time: input closes after an accept.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction accepted back to back");

  // A result appears only while the input side is closed.
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while input was open");

endmodule

bind trial_move_pair_energy_delta tmpe_checker u_tmpe_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_if.valid),
  .in_ready      (in_if.ready),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .energy_change (out_if.energy_change),
  .moved_x       (out_if.moved_x),
  .moved_y       (out_if.moved_y),
  .moved_z       (out_if.moved_z),
  .bad_index     (out_if.bad_index)
);
